### rtl/bloom_filter_insert_query_macros.svh
// Assertion macros used by the checker file.
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define BFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `BFQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/bfq_pkg.sv
package bfq_pkg;

  localparam int MaxBitsDef   = 65536;
  localparam int HashCountDef = 7;
  localparam int CfgW         = 17;
  localparam int KeyW         = 32;
  localparam int CfgMaxVal    = 131071;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CONV, ST_NORM, ST_SEED, ST_FEED,
    ST_MIX1, ST_MIX2, ST_MIX3, ST_TMIX1, ST_TMIX2, ST_TMIX3,
    ST_FIN1, ST_FIN2, ST_FIN3, ST_DIV, ST_MEMA, ST_MEMB, ST_DONE
  } bfq_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_CONV, OP_NORM, OP_SEED, OP_FEED,
    OP_K1, OP_K2, OP_HBLK, OP_HTAIL, OP_FIN1, OP_FIN2, OP_FIN3,
    OP_DIV, OP_MEMA, OP_MEMB, OP_OUT
  } bfq_op_e;

  typedef struct packed {
    bfq_op_e op;
    logic    in_ready;
  } bfq_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic conv_done;
    logic norm_done;
    logic nb_full;
    logic feed_last;
    logic text_done;
    logic div_done;
    logic last_seed;
    logic is_query;
    logic out_busy;
  } bfq_sts_t;

endpackage

### rtl/bfq_ram.sv
module bfq_ram #(
  parameter int Width = 1,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/bfq_ctrl.sv
module bfq_ctrl import bfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  bfq_sts_t sts_i,
  output bfq_cmd_t cmd_o
);

  bfq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_CONV;
      ST_CONV:  if (sts_i.conv_done) state_d = ST_NORM;
      ST_NORM:  if (sts_i.norm_done) state_d = ST_SEED;
      ST_SEED:  state_d = ST_FEED;
      ST_FEED: begin
        if (sts_i.nb_full) begin
          state_d = ST_MIX1;
        end else if (sts_i.feed_last) begin
          state_d = ST_TMIX1;
        end
      end
      ST_MIX1:  state_d = ST_MIX2;
      ST_MIX2:  state_d = ST_MIX3;
      ST_MIX3:  state_d = sts_i.text_done ? ST_FIN1 : ST_FEED;
      ST_TMIX1: state_d = ST_TMIX2;
      ST_TMIX2: state_d = ST_TMIX3;
      ST_TMIX3: state_d = ST_FIN1;
      ST_FIN1:  state_d = ST_FIN2;
      ST_FIN2:  state_d = ST_FIN3;
      ST_FIN3:  state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_done) state_d = ST_MEMA;
      ST_MEMA: begin
        if (sts_i.is_query) begin
          state_d = ST_MEMB;
        end else begin
          state_d = sts_i.last_seed ? ST_DONE : ST_SEED;
        end
      end
      ST_MEMB:  state_d = sts_i.last_seed ? ST_DONE : ST_SEED;
      ST_DONE:  if (!sts_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = OP_NONE;
    unique case (state_q)
      ST_CLEAR: cmd_o.op = OP_CLEAR;
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.op       = in_valid_i ? OP_LOAD : OP_NONE;
      end
      ST_CONV:  cmd_o.op = OP_CONV;
      ST_NORM:  cmd_o.op = OP_NORM;
      ST_SEED:  cmd_o.op = OP_SEED;
      ST_FEED:  cmd_o.op = OP_FEED;
      ST_MIX1, ST_TMIX1: cmd_o.op = OP_K1;
      ST_MIX2, ST_TMIX2: cmd_o.op = OP_K2;
      ST_MIX3:  cmd_o.op = OP_HBLK;
      ST_TMIX3: cmd_o.op = OP_HTAIL;
      ST_FIN1:  cmd_o.op = OP_FIN1;
      ST_FIN2:  cmd_o.op = OP_FIN2;
      ST_FIN3:  cmd_o.op = OP_FIN3;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_MEMA:  cmd_o.op = OP_MEMA;
      ST_MEMB:  cmd_o.op = OP_MEMB;
      ST_DONE:  cmd_o.op = sts_i.out_busy ? OP_NONE : OP_OUT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

### rtl/bfq_datapath.sv
module bfq_datapath import bfq_pkg::*; #(
  parameter int MaxBits   = MaxBitsDef,
  parameter int HashCount = HashCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfq_cmd_t           cmd_i,
  output bfq_sts_t           sts_o,
  input  logic               in_action_i,
  input  logic [KeyW-1:0]    in_key_i,
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_bit_o
);

  localparam int IdxW  = $clog2(MaxBits);
  localparam int SeedW = $clog2(HashCount + 1);
  localparam int SizeMax = (MaxBits < CfgMaxVal) ? MaxBits : CfgMaxVal;
  localparam int SizeRst = (MaxBits < 65536) ? MaxBits : 65536;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;
  localparam logic [31:0] HAdd = 32'he6546b64;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChBar = 8'h7c;

  typedef enum logic [2:0] {PH_SIGN, PH_KEY, PH_BAR, PH_SIZE, PH_END} bfq_phase_e;

  function automatic logic [39:0] dab10(input logic [39:0] v);
    logic [39:0] r;
    r = v;
    for (int i = 0; i < 10; i++) begin
      if (r[4*i +: 4] >= 4'd5) r[4*i +: 4] = r[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

  function automatic logic [23:0] dab6(input logic [23:0] v);
    logic [23:0] r;
    r = v;
    for (int i = 0; i < 6; i++) begin
      if (r[4*i +: 4] >= 4'd5) r[4*i +: 4] = r[4*i +: 4] + 4'd3;
    end
    return r;
  endfunction

  // Control state.
  logic [CfgW-1:0]  filt_q;
  logic [IdxW-1:0]  clr_q;
  logic             out_valid_q;
  // Payload and working state.
  logic             act_q, neg_q, allset_q, out_bit_q;
  logic [31:0]      bink_q, bins_q, kacc_q, k_q, h_q, dvd_q;
  logic [39:0]      kbcd_q, ksh_q;
  logic [23:0]      sbcd_q, ssh_q;
  logic [3:0]       kn_q, krem_q;
  logic [2:0]       sn_q, srem_q;
  logic [4:0]       cnt_q, len_q;
  logic [SeedW-1:0] seed_q;
  bfq_phase_e       ph_q;
  logic [1:0]       nb_q;
  logic [CfgW-1:0]  rem_q;

  logic             k_shift, s_shift;
  logic [39:0]      kdab;
  logic [23:0]      sdab;
  logic [7:0]       byte_c;
  logic [31:0]      t1, t2;
  logic [CfgW:0]    rtry, rsub;
  logic [IdxW+CfgW-1:0] idx_ext;
  logic [IdxW-1:0]  idx;
  logic             ram_we, ram_wd, ram_rd;
  logic [IdxW-1:0]  ram_wa;

  assign k_shift = (kbcd_q[39:36] == 4'd0) && (kn_q > 4'd1);
  assign s_shift = (sbcd_q[23:20] == 4'd0) && (sn_q > 3'd1);
  assign kdab = dab10(kbcd_q);
  assign sdab = dab6(sbcd_q);
  assign t1 = (h_q ^ {27'd0, len_q}) ^ ((h_q ^ {27'd0, len_q}) >> 16);
  assign t2 = h_q ^ (h_q >> 13);
  assign rtry = {rem_q, dvd_q[31]};
  assign rsub = rtry - {1'b0, filt_q};
  assign idx_ext = {{IdxW{1'b0}}, rem_q};
  assign idx = idx_ext[IdxW-1:0];

  always_comb begin
    case (ph_q)
      PH_SIGN: byte_c = ChMinus;
      PH_KEY:  byte_c = {4'h3, ksh_q[39:36]};
      PH_BAR:  byte_c = ChBar;
      PH_SIZE: byte_c = {4'h3, ssh_q[23:20]};
      default: byte_c = 8'd0;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = idx;
    ram_wd = 1'b1;
    if (cmd_i.op == OP_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_q;
      ram_wd = 1'b0;
    end else if (cmd_i.op == OP_MEMA && !act_q) begin
      ram_we = 1'b1;
    end
  end

  bfq_ram #(.Width(1), .Depth(MaxBits)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (idx),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q      <= CfgW'(SizeRst);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_data_i < CfgW'(8)) begin
          filt_q <= CfgW'(8);
        end else if (cfg_data_i > CfgW'(SizeMax)) begin
          filt_q <= CfgW'(SizeMax);
        end else begin
          filt_q <= cfg_data_i;
        end
      end
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + 1'b1;
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        act_q    <= in_action_i;
        neg_q    <= in_key_i[31];
        bink_q   <= in_key_i[31] ? (~in_key_i + 32'd1) : in_key_i;
        bins_q   <= {{(32-CfgW){1'b0}}, filt_q};
        kbcd_q   <= '0;
        sbcd_q   <= '0;
        kn_q     <= 4'd10;
        sn_q     <= 3'd6;
        cnt_q    <= '0;
        seed_q   <= '0;
        allset_q <= 1'b1;
      end
      OP_CONV: begin
        kbcd_q <= {kdab[38:0], bink_q[31]};
        sbcd_q <= {sdab[22:0], bins_q[31]};
        bink_q <= bink_q << 1;
        bins_q <= bins_q << 1;
        cnt_q  <= cnt_q + 5'd1;
      end
      OP_NORM: begin
        if (k_shift) begin
          kbcd_q <= kbcd_q << 4;
          kn_q   <= kn_q - 4'd1;
        end
        if (s_shift) begin
          sbcd_q <= sbcd_q << 4;
          sn_q   <= sn_q - 3'd1;
        end
      end
      OP_SEED: begin
        h_q    <= {{(32-SeedW){1'b0}}, seed_q};
        seed_q <= seed_q + 1'b1;
        ksh_q  <= kbcd_q;
        ssh_q  <= sbcd_q;
        krem_q <= kn_q;
        srem_q <= sn_q;
        ph_q   <= neg_q ? PH_SIGN : PH_KEY;
        nb_q   <= 2'd0;
        kacc_q <= '0;
        len_q  <= {4'd0, neg_q} + {1'b0, kn_q} + 5'd1 + {2'd0, sn_q};
      end
      OP_FEED: begin
        kacc_q[8*nb_q +: 8] <= byte_c;
        nb_q <= nb_q + 2'd1;
        case (ph_q)
          PH_SIGN: ph_q <= PH_KEY;
          PH_KEY: begin
            ksh_q  <= ksh_q << 4;
            krem_q <= krem_q - 4'd1;
            if (krem_q == 4'd1) ph_q <= PH_BAR;
          end
          PH_BAR:  ph_q <= PH_SIZE;
          PH_SIZE: begin
            ssh_q  <= ssh_q << 4;
            srem_q <= srem_q - 3'd1;
            if (srem_q == 3'd1) ph_q <= PH_END;
          end
          default: ph_q <= PH_END;
        endcase
      end
      OP_K1:    k_q <= kacc_q * C1;
      OP_K2:    k_q <= {k_q[16:0], k_q[31:17]} * C2;
      OP_HBLK: begin
        h_q    <= {h_q[18:0] ^ k_q[18:0], h_q[31:19] ^ k_q[31:19]} * 32'd5 + HAdd;
        kacc_q <= '0;
      end
      OP_HTAIL: h_q <= h_q ^ k_q;
      OP_FIN1:  h_q <= t1 * F1;
      OP_FIN2:  h_q <= t2 * F2;
      OP_FIN3: begin
        dvd_q <= h_q ^ (h_q >> 16);
        rem_q <= '0;
        cnt_q <= '0;
      end
      OP_DIV: begin
        rem_q <= (rtry >= {1'b0, filt_q}) ? rsub[CfgW-1:0] : rtry[CfgW-1:0];
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + 5'd1;
      end
      OP_MEMB:  allset_q <= allset_q & ram_rd;
      OP_OUT:   out_bit_q <= act_q & allset_q;
      default:  ;
    endcase
  end

  always_comb begin
    sts_o.clr_done  = (clr_q == IdxW'(MaxBits - 1));
    sts_o.conv_done = (cnt_q == 5'd31);
    sts_o.norm_done = !k_shift && !s_shift;
    sts_o.nb_full   = (nb_q == 2'd3);
    sts_o.feed_last = (ph_q == PH_SIZE) && (srem_q == 3'd1);
    sts_o.text_done = (ph_q == PH_END);
    sts_o.div_done  = (cnt_q == 5'd31);
    sts_o.last_seed = (seed_q == SeedW'(HashCount));
    sts_o.is_query  = act_q;
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;

endmodule

### rtl/bloom_filter_insert_query.sv
// Channel  | Direction | Fields (low bit first)
// s_axis   | in        | tuser: action; tdata: key_value
// m_axis   | out       | tdata: maybe_present, zero-padded to a byte
// cfg_wr   | in        | filter_bits, written when cfg_wr_en_i is high
//
// After reset a clearing pass writes zero to every cell of the bit store, one by one;
// no item is accepted until it ends, though size writes are taken throughout.
// Each item is turned into a decimal text key of length L (at most 18), trimmed of
// leading zero digits, and hashed NUM_HASHES times; a query also reads the store for
// each hash. The 32-step remainder and the byte-serial hash dominate.
// A waiting result does not block input; only the next item's end holds until it goes.
module bloom_filter_insert_query import bfq_pkg::*; #(
  parameter int MAX_BITS   = MaxBitsDef,
  parameter int NUM_HASHES = HashCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,  // [31:0] key_value (signed)
  input  logic            s_axis_tuser,  // [0] action: 0 insert, 1 query
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [0] maybe_present, [7:1] zero
  input  logic            cfg_wr_en_i,
  input  logic [CfgW-1:0] cfg_wr_data_i
);

  bfq_cmd_t cmd;
  bfq_sts_t sts;
  logic     out_bit;

  // The controller sequences each item: decimal conversion, digit trim, then per
  // seed the text stream, block mixing, finalisation, remainder and store access.
  bfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the key text, hash state, divider and the bit store.
  bfq_datapath #(
    .MaxBits   (MAX_BITS),
    .HashCount (NUM_HASHES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_action_i (s_axis_tuser),
    .in_key_i    (s_axis_tdata),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_data_i  (cfg_wr_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bit_o   (out_bit)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {7'd0, out_bit};

endmodule

### rtl/bfq_checker.sv
`include "bloom_filter_insert_query_macros.svh"

module bfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  `BFQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `BFQ_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed")
  `BFQ_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item taken while busy")
  `BFQ_ASSERT(a_pad, m_axis_tdata[7:1] == 7'd0, "padding bits set")

endmodule

bind bloom_filter_insert_query bfq_checker u_bfq_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import bfq_pkg::*;

  localparam int unsigned FilterCells = MaxBitsDef;

  // Actions carried in tuser.
  localparam logic ActInsert = 1'b0;
  localparam logic ActQuery  = 1'b1;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata;
  logic            s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [7:0]      m_axis_tdata;
  logic            cfg_wr_en_i;
  logic [CfgW-1:0] cfg_wr_data_i;

  bloom_filter_insert_query i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Own copy of the filter: the cells and the saturated size.
  bit          filter_cells [FilterCells];
  logic [16:0] filter_size;

  // Answers still owed by the block, oldest first.
  logic        answer_q [$];
  // Keys already inserted, used to build queries that should hit.
  int          inserted_keys [$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned answers_seen;
  int unsigned hits_seen;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Decimal digits of v appended at txt[pos]; returns the new length.
  function automatic int put_decimal(inout logic [7:0] txt [32], input int pos,
                                     input logic [31:0] v);
    logic [7:0] digits [10];
    int         n;
    n = 0;
    do begin
      digits[n] = 8'd48 + 8'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < 10);
    while (n > 0) begin
      n--;
      txt[pos] = digits[n];
      pos++;
    end
    return pos;
  endfunction

  function automatic logic [31:0] murmur32(input logic [7:0] txt [32], input int len,
                                           input logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    int          blk;
    h = seed;
    for (blk = 0; blk < len / 4; blk++) begin
      k = {txt[4*blk+3], txt[4*blk+2], txt[4*blk+1], txt[4*blk]};
      k = k * 32'hcc9e2d51;
      k = {k[16:0], k[31:17]};
      k = k * 32'h1b873593;
      h = h ^ k;
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + 32'he6546b64;
    end
    k = '0;
    if (len % 4 == 3) k = k ^ {8'd0, txt[4*blk+2], 16'd0};
    if (len % 4 >= 2) k = k ^ {16'd0, txt[4*blk+1], 8'd0};
    if (len % 4 >= 1) begin
      k = k ^ {24'd0, txt[4*blk]};
      k = k * 32'hcc9e2d51;
      k = {k[16:0], k[31:17]};
      k = k * 32'h1b873593;
      h = h ^ k;
    end
    h = h ^ 32'(len);
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Applies one item to the local filter and returns the expected answer.
  function automatic logic filter_answer(input logic act, input logic [31:0] key);
    logic [7:0]  txt [32];
    logic [31:0] idx;
    int          len;
    logic        all_set;
    len = 0;
    all_set = 1'b1;
    if (key[31]) begin
      txt[0] = 8'h2d;
      len = put_decimal(txt, 1, ~key + 32'd1);
    end else begin
      len = put_decimal(txt, 0, key);
    end
    txt[len] = 8'h7c;
    len = put_decimal(txt, len + 1, 32'(filter_size));
    for (int s = 0; s < HashCountDef; s++) begin
      idx = murmur32(txt, len, 32'(s)) % 32'(filter_size);
      if (act == ActInsert) filter_cells[idx] = 1'b1;
      else if (!filter_cells[idx]) all_set = 1'b0;
    end
    return act == ActQuery && all_set;
  endfunction

  // Writes the size register; the local copy saturates as the block does.
  task automatic write_size(input logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b1;
    cfg_wr_data_i = v;
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b0;
    if (v < 8) filter_size = 17'd8;
    else if (v > FilterCells) filter_size = 17'(FilterCells);
    else filter_size = v;
  endtask

  // Offers one item; the answer is worked out at the edge where it is taken.
  // When typed_known is set, the typed answer is owed instead of the predicted one.
  task automatic send_item(input logic act, input logic [31:0] key,
                           input bit typed_known, input logic typed_answer);
    logic predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = $urandom;
      s_axis_tuser  = $urandom_range(1);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = key;
    s_axis_tuser  = act;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = filter_answer(act, key);
    answer_q.push_back(typed_known ? typed_answer : predicted);
    if (act == ActInsert) inserted_keys.push_back(key);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Lets every owed answer arrive, then a short pause.
  task automatic drain();
    stop_sending();
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(5))
      0: return 32'($urandom_range(0, 9));
      1: return -32'($urandom_range(1, 999));
      2: return 32'($urandom_range(0, 200000));
      3: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'hffff_ffff;
           default: return 32'h0;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // The receiver lowers tready at random, as set for the phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker.
  initial begin
    logic owed;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        answers_seen++;
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("answer 0x%02h with none owed", m_axis_tdata));
        end else begin
          owed = answer_q.pop_front();
          if (m_axis_tdata[0] != owed)
            report_mismatch($sformatf("maybe_present %0b, expected %0b",
                                      m_axis_tdata[0], owed));
          if (m_axis_tdata[7:1] != 7'd0)
            report_mismatch($sformatf("padding bits 0x%02h not zero", m_axis_tdata[7:1]));
          if (m_axis_tdata[0] === 1'b1) hits_seen++;
        end
      end
    end
  end

  // Directed rows: action, key, whether the answer is typed, typed answer.
  typedef struct {
    logic        act;
    logic [31:0] key;
    bit          known;
    logic        answer;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{ActQuery,  32'd0,         1, 1'b0},
    '{ActQuery,  32'h8000_0000, 1, 1'b0},
    '{ActInsert, 32'd0,         1, 1'b0},
    '{ActQuery,  32'd0,         0, 1'b0},
    '{ActInsert, 32'h8000_0000, 1, 1'b0},
    '{ActQuery,  32'h8000_0000, 0, 1'b0},
    '{ActInsert, 32'h7fff_ffff, 1, 1'b0},
    '{ActQuery,  32'h7fff_ffff, 0, 1'b0},
    '{ActQuery,  32'hffff_ffff, 0, 1'b0},
    '{ActInsert, 32'hffff_ffff, 1, 1'b0},
    '{ActQuery,  32'hffff_ffff, 0, 1'b0},
    '{ActInsert, 32'd9,         1, 1'b0},
    '{ActQuery,  32'd9,         0, 1'b0},
    '{ActQuery,  32'd10,        0, 1'b0},
    '{ActInsert, 32'd1234567890, 1, 1'b0},
    '{ActQuery,  32'd1234567890, 0, 1'b0},
    '{ActQuery,  32'd1,         0, 1'b0}
  };

  // Sizes visited by the random phases; out-of-range values saturate.
  logic [CfgW-1:0] phase_sizes [] = '{
    17'd8, 17'd0, 17'd100, 17'd131071, 17'd7, 17'd1000, 17'd64, 17'd65537, 17'd12345
  };

  initial begin
    logic [31:0] key;
    logic        act;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_wr_en_i    = 1'b0;
    cfg_wr_data_i  = '0;
    error_count    = 0;
    items_sent     = 0;
    answers_seen   = 0;
    hits_seen      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    filter_size    = 17'(FilterCells);
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset size, with the cells freshly cleared.
    foreach (dir_rows[r])
      send_item(dir_rows[r].act, dir_rows[r].key, dir_rows[r].known, dir_rows[r].answer);
    drain();
    // One of the same keys, queried at the full size, written explicitly this time.
    write_size(17'd65536);
    send_item(ActQuery, 32'h8000_0000, 0, 1'b0);
    drain();

    // Random phases. The cells are never cleared on a size change, so earlier
    // inserts stay visible; most queries reuse inserted keys to reach hits.
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int n = 0; n < 200; n++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5: begin act = ActInsert; key = pick_key(); end
          6, 7, 8: begin act = ActQuery; key = pick_key(); end
          default: begin
            act = ActQuery;
            key = inserted_keys.size() != 0 ?
                  inserted_keys[$urandom_range(inserted_keys.size() - 1)] : pick_key();
          end
        endcase
        send_item(act, key, 0, 1'b0);
      end
      drain();
    end

    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
    $display("Covered %0d items over %0d sizes and four idling patterns;",
             items_sent, phase_sizes.size() + 1);
    $display("%0d answers checked, %0d of them maybe-present.", answers_seen, hits_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #(64'd100_000_000);
    $display("Timed out with %0d answers still owed.", answer_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
